// ===== src/resident_number_token_checker_core_assert.svh =====
// assertion macros used by the checker file
`ifndef RESIDENT_NUMBER_TOKEN_CHECKER_CORE_ASSERT_SVH
`define RESIDENT_NUMBER_TOKEN_CHECKER_CORE_ASSERT_SVH

// property checked on every clock edge outside reset
`define RNTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define RNTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rntc_pkg.sv =====
// shared types, constants and table functions of the token checker
package rntc_pkg;

  localparam int CHAR_W  = 16;
  localparam int SUM_W   = 24;
  localparam int COUNT_W = 32;
  localparam int POS_W   = 5;
  localparam int Q_W     = 20;
  localparam int OUT_W   = 40;

  // character index limits
  localparam logic [POS_W-1:0] POS_LIMIT        = 5'd27;
  localparam logic [POS_W-1:0] CHECK_IDX_NEAR   = 5'd13;
  localparam logic [POS_W-1:0] CHECK_IDX_SPREAD = 5'd26;
  localparam logic [POS_W-1:0] SEP_IDX_NEAR     = 5'd6;
  localparam logic [POS_W-1:0] SEP_IDX_MID      = 5'd12;
  localparam logic [POS_W-1:0] SEP_IDX_LAST     = 5'd25;

  // character codes
  localparam logic [CHAR_W-1:0] DASH_CODE = 16'd45;
  localparam logic [CHAR_W-1:0] ZERO_CODE = 16'd48;

  // reciprocal of 11 scaled by 2^27, exact for dividends below 2^25
  localparam int RECIP_SHIFT = 27;
  localparam logic [SUM_W-1:0] RECIP_11 = 24'd12201612;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_DASH    = 2'd1,
    MODE_SPECIAL = 2'd2,
    MODE_SPREAD  = 2'd3
  } mode_t;

  // finished token handed to the check stage
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [CHAR_W-1:0] check_char;
    logic              eligible;
  } fin_t;

  // code from 33 up that is neither a digit nor a letter
  function automatic logic is_special(logic [CHAR_W-1:0] c);
    logic res;
    res = 1'b1;
    if (c < 16'd33) res = 1'b0;
    if (c > 16'd47 && c < 16'd58) res = 1'b0;
    if (c > 16'd64 && c < 16'd91) res = 1'b0;
    if (c > 16'd96 && c < 16'd123) res = 1'b0;
    return res;
  endfunction

  // digit weight for a character index under a mode
  function automatic logic [3:0] weight(mode_t m, logic [POS_W-1:0] idx);
    logic [3:0] w;
    w = 4'd0;
    if (m == MODE_DASH || m == MODE_SPECIAL) begin
      case (idx)
        5'd0:  w = 4'd2;
        5'd1:  w = 4'd3;
        5'd2:  w = 4'd4;
        5'd3:  w = 4'd5;
        5'd4:  w = 4'd6;
        5'd5:  w = 4'd7;
        5'd7:  w = 4'd8;
        5'd8:  w = 4'd9;
        5'd9:  w = 4'd2;
        5'd10: w = 4'd3;
        5'd11: w = 4'd4;
        5'd12: w = 4'd5;
        default: w = 4'd0;
      endcase
    end else if (m == MODE_SPREAD) begin
      case (idx)
        5'd0:  w = 4'd2;
        5'd2:  w = 4'd3;
        5'd4:  w = 4'd4;
        5'd6:  w = 4'd5;
        5'd8:  w = 4'd6;
        5'd10: w = 4'd7;
        5'd14: w = 4'd8;
        5'd16: w = 4'd9;
        5'd18: w = 4'd2;
        5'd20: w = 4'd3;
        5'd22: w = 4'd4;
        5'd24: w = 4'd5;
        default: w = 4'd0;
      endcase
    end
    return w;
  endfunction

  // expected check digit (11 - rem) % 10 from the remainder magnitude and sign
  function automatic logic [3:0] expect_digit(logic neg, logic [3:0] r);
    logic [3:0] d;
    if (neg) begin
      case (r)
        4'd9:    d = 4'd0;
        4'd10:   d = 4'd1;
        default: d = 4'(r + 4'd1);
      endcase
    end else begin
      case (r)
        4'd0:    d = 4'd1;
        4'd1:    d = 4'd0;
        default: d = 4'(4'd11 - r);
      endcase
    end
    return d;
  endfunction

endpackage

// ===== src/rntc_token_acc.sv =====
// input register, per-token accumulation and finished-token register
module rntc_token_acc (
  input  logic                          clk,
  input  logic                          rst,
  input  rntc_pkg::mode_t               mode,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rntc_pkg::CHAR_W-1:0]   in_char,
  input  logic                          in_last,
  output logic                          fin_valid,
  input  logic                          fin_ready,
  output rntc_pkg::fin_t                fin
);

  // input register
  logic                        s1_v;
  logic [rntc_pkg::CHAR_W-1:0] s1_char;
  logic                        s1_last;

  // token state
  logic [rntc_pkg::POS_W-1:0]  position;
  logic [rntc_pkg::SUM_W-1:0]  weighted_sum;
  logic                        separators_ok;
  logic [rntc_pkg::CHAR_W-1:0] check_char;

  logic [rntc_pkg::POS_W-1:0]  position_next;
  logic [rntc_pkg::SUM_W-1:0]  weighted_sum_next;
  logic                        separators_ok_next;
  logic [rntc_pkg::CHAR_W-1:0] check_char_next;

  logic                        fin_go;
  logic                        s1_adv;
  logic [rntc_pkg::POS_W-1:0]  check_idx;
  logic [3:0]                  w;
  logic signed [16:0]          digit_val;
  logic signed [21:0]          prod;
  logic                        sep_fail;

  // handshake between stages
  assign fin_go   = !fin_valid || fin_ready;
  assign s1_adv   = s1_v && (!s1_last || fin_go);
  assign in_ready = !s1_v || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_ready) begin
      s1_v <= in_valid;
    end
    if (in_ready) begin
      s1_char <= in_char;
      s1_last <= in_last;
    end
  end

  // weigh the character, test separators and form the next token state
  always_comb begin
    check_idx = (mode == rntc_pkg::MODE_SPREAD) ? rntc_pkg::CHECK_IDX_SPREAD
                                                : rntc_pkg::CHECK_IDX_NEAR;
    w         = rntc_pkg::weight(mode, position);
    digit_val = $signed({1'b0, s1_char}) - 17'sd48;
    prod      = digit_val * $signed({1'b0, w});
    sep_fail  = 1'b0;
    unique case (mode)
      rntc_pkg::MODE_DASH:
        sep_fail = (position == rntc_pkg::SEP_IDX_NEAR) && (s1_char != rntc_pkg::DASH_CODE);
      rntc_pkg::MODE_SPECIAL:
        sep_fail = (position == rntc_pkg::SEP_IDX_NEAR) && !rntc_pkg::is_special(s1_char);
      rntc_pkg::MODE_SPREAD:
        sep_fail = ((position[0] && position <= rntc_pkg::SEP_IDX_LAST) ||
                    position == rntc_pkg::SEP_IDX_MID) && !rntc_pkg::is_special(s1_char);
      default:
        sep_fail = 1'b0;
    endcase

    position_next      = position;
    weighted_sum_next  = weighted_sum;
    separators_ok_next = separators_ok;
    check_char_next    = check_char;
    if (position < rntc_pkg::POS_LIMIT) begin
      weighted_sum_next  = weighted_sum + {{2{prod[21]}}, prod};
      separators_ok_next = separators_ok && !sep_fail;
      if (position == check_idx && mode != rntc_pkg::MODE_OFF) begin
        check_char_next = s1_char;
      end
      position_next = position + 5'd1;
    end
  end

  // token state update, cleared after the last character
  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      weighted_sum  <= '0;
      separators_ok <= 1'b1;
      check_char    <= '0;
    end else if (s1_adv) begin
      if (s1_last) begin
        position      <= '0;
        weighted_sum  <= '0;
        separators_ok <= 1'b1;
        check_char    <= '0;
      end else begin
        position      <= position_next;
        weighted_sum  <= weighted_sum_next;
        separators_ok <= separators_ok_next;
        check_char    <= check_char_next;
      end
    end
  end

  // finished-token register
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_go) begin
      fin_valid <= s1_v && s1_last;
    end
    if (fin_go) begin
      fin.sum        <= weighted_sum_next;
      fin.check_char <= check_char_next;
      fin.eligible   <= (mode != rntc_pkg::MODE_OFF) && (position >= check_idx) &&
                        separators_ok_next;
    end
  end

endmodule

// ===== src/rntc_check.sv =====
// mod-11 reduction, check digit compare, match counter and result register
module rntc_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fin_valid,
  output logic                          fin_ready,
  input  rntc_pkg::fin_t                fin,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_matched,
  output logic [rntc_pkg::COUNT_W-1:0]  out_count
);

  // quotient stage
  logic                        s3_v;
  logic [rntc_pkg::SUM_W-1:0]  s3_abs;
  logic [rntc_pkg::Q_W-1:0]    s3_q;
  logic                        s3_neg;
  logic                        s3_eligible;
  logic [rntc_pkg::CHAR_W-1:0] s3_check_char;

  logic [rntc_pkg::COUNT_W-1:0] match_count;
  logic [rntc_pkg::COUNT_W-1:0] match_count_next;

  logic                          s3_go;
  logic                          out_free;
  logic [rntc_pkg::SUM_W-1:0]    abs_val;
  logic [2*rntc_pkg::SUM_W-1:0]  qprod;
  logic [rntc_pkg::SUM_W-1:0]    q_ext;
  logic [rntc_pkg::SUM_W-1:0]    q11;
  logic [rntc_pkg::SUM_W-1:0]    rdiff;
  logic [3:0]                    expect_d;
  logic                          matched;

  assign out_free  = !out_valid || out_ready;
  assign s3_go     = !s3_v || out_free;
  assign fin_ready = s3_go;

  // magnitude of the signed sum and its quotient by 11
  always_comb begin
    abs_val = fin.sum[rntc_pkg::SUM_W-1] ? (~fin.sum + 24'd1) : fin.sum;
    qprod   = {{rntc_pkg::SUM_W{1'b0}}, abs_val} *
              {{rntc_pkg::SUM_W{1'b0}}, rntc_pkg::RECIP_11};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (s3_go) begin
      s3_v <= fin_valid;
    end
    if (s3_go) begin
      s3_abs        <= abs_val;
      s3_q          <= qprod[rntc_pkg::RECIP_SHIFT +: rntc_pkg::Q_W];
      s3_neg        <= fin.sum[rntc_pkg::SUM_W-1];
      s3_eligible   <= fin.eligible;
      s3_check_char <= fin.check_char;
    end
  end

  // remainder, expected digit and saturating count
  always_comb begin
    q_ext    = {{(rntc_pkg::SUM_W-rntc_pkg::Q_W){1'b0}}, s3_q};
    q11      = (q_ext << 3) + (q_ext << 1) + q_ext;
    rdiff    = s3_abs - q11;
    expect_d = rntc_pkg::expect_digit(s3_neg, rdiff[3:0]);
    matched  = s3_eligible &&
               (s3_check_char == ({12'd0, expect_d} + rntc_pkg::ZERO_CODE));
    match_count_next = match_count;
    if (matched && match_count != '1) begin
      match_count_next = match_count + 32'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      match_count <= '0;
    end else if (out_free) begin
      out_valid <= s3_v;
      if (s3_v) begin
        match_count <= match_count_next;
      end
    end
    if (out_free) begin
      out_matched <= matched;
      out_count   <= match_count_next;
    end
  end

endmodule

// ===== src/resident_number_token_checker_core.sv =====
// top level of the resident registration number token checker
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+----------------------------------------
//  s_*     | in  | s_tvalid / s_tready | s_tdata: char_code; s_tlast: last_of_token
//  m_*     | out | m_tvalid / m_tready | m_tdata: matched, match_count
//  cfg_*   | in  | cfg_we              | cfg_wdata: mode
//
// one character is taken every cycle while the result side keeps up
// after its last-character transfer a result passes the input, finished-token, quotient and result registers
// (accumulate, quotient by reciprocal multiply, remainder and compare)
// reset sets mode to dash separator with a zero count
// a stalled result holds only the full stages; mid-token characters keep flowing
module resident_number_token_checker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] char_code
  input  logic        s_tlast,   // last_of_token
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [rntc_pkg::OUT_W-1:0] m_tdata  // [0] matched, [32:1] match_count, [39:33] zero
);

  rntc_pkg::mode_t mode;

  logic                          fin_valid;
  logic                          fin_ready;
  rntc_pkg::fin_t                fin;
  logic                          out_matched;
  logic [rntc_pkg::COUNT_W-1:0]  out_count;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= rntc_pkg::MODE_DASH;
    end else if (cfg_we) begin
      mode <= rntc_pkg::mode_t'(cfg_wdata);
    end
  end

  rntc_token_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_char   (s_tdata),
    .in_last   (s_tlast),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin)
  );

  rntc_check u_check (
    .clk         (clk),
    .rst         (rst),
    .fin_valid   (fin_valid),
    .fin_ready   (fin_ready),
    .fin         (fin),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_matched (out_matched),
    .out_count   (out_count)
  );

  // pack result fields
  assign m_tdata = {7'd0, out_count, out_matched};

endmodule

// ===== src/rntc_checker.sv =====
// port-level assertions for the token checker, bound to the top level
`include "resident_number_token_checker_core_assert.svh"

module rntc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  logic [31:0] prev_count;
  logic        seen;
  logic        out_xfer;
  logic [31:0] cur_count;
  logic [31:0] hit_inc;
  logic        first_ok;
  logic        step_ok;

  assign out_xfer  = m_tvalid && m_tready;
  assign cur_count = m_tdata[32:1];
  assign hit_inc   = {31'd0, m_tdata[0]};

  // count moves by one per match and holds once saturated
  assign first_ok = (cur_count == hit_inc);
  assign step_ok  = (cur_count == prev_count + hit_inc) ||
                    (prev_count == 32'hFFFF_FFFF && cur_count == prev_count);

  // count of the last result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_count <= '0;
      seen       <= 1'b0;
    end else if (out_xfer) begin
      prev_count <= cur_count;
      seen       <= 1'b1;
    end
  end

  `RNTC_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid, "result valid right after reset")
  `RNTC_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `RNTC_ASSERT(a_first_count, out_xfer && !seen |-> first_ok, "first count wrong")
  `RNTC_ASSERT(a_count_step, out_xfer && seen |-> step_ok, "count does not follow matches")
  `RNTC_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[39:33] == 7'd0, "result padding not zero")

endmodule

bind resident_number_token_checker_core rntc_checker u_rntc_checker (.*);
